// File: design/banded_lcss_similarity_assert.svh
// ----------------------------------------------------------------------------
// banded_lcss_similarity_assert.svh
// Assertion macros used by the banded LCSS cell stage (blsim_cell).
// ----------------------------------------------------------------------------
`ifndef BANDED_LCSS_SIMILARITY_ASSERT_SVH
`define BANDED_LCSS_SIMILARITY_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define BLSIM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define BLSIM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/blsim_pkg.sv
// ----------------------------------------------------------------------------
// blsim_pkg
// Shared widths, register indexes and types of the banded LCSS block.
// ----------------------------------------------------------------------------
package blsim_pkg;

    localparam int VAL_W      = 11;
    localparam int DIST_W     = 32;
    localparam int REFLEN_W   = 11;
    localparam int BAND_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic [VAL_W-1:0] t_val;

    localparam t_val VALUE_CAP = '1;

    localparam logic [CFG_IDX_W-1:0] REG_REF_LENGTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH      = 2'd2;

    typedef struct packed {
        logic match;
        logic first_row;
        logic col_zero;
        logic last;
        logic too_long;
    } t_cell_ctl;

endpackage

// File: design/blsim_if.sv
// ----------------------------------------------------------------------------
// blsim_if
// Valid/ready channels of the banded LCSS block: cells in, results out,
// register writes.
// ----------------------------------------------------------------------------
interface blsim_in_if;
    import blsim_pkg::*;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] pair_distance;
    logic              last_cell;
    modport source (output valid, output pair_distance, output last_cell, input ready);
    modport sink   (input valid, input pair_distance, input last_cell, output ready);
endinterface

interface blsim_out_if;
    import blsim_pkg::*;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] lcss_length;
    logic             too_long;
    modport source (output valid, output lcss_length, output too_long, input ready);
    modport sink   (input valid, input lcss_length, input too_long, output ready);
endinterface

interface blsim_cfg_if;
    import blsim_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/blsim_ram.sv
// ----------------------------------------------------------------------------
// blsim_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module blsim_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/blsim_seq.sv
// ----------------------------------------------------------------------------
// blsim_seq
// Register file and cell sequencer: tracks row and column, clamps the
// reference length, evaluates the band and threshold test per cell.
// ----------------------------------------------------------------------------
module blsim_seq #(
    parameter int MAX_REF_FRAMES   = 1024,
    parameter int MAX_INPUT_FRAMES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    blsim_cfg_if.sink                     i_cfg,
    input  logic                          i_load,
    input  logic [blsim_pkg::DIST_W-1:0]  i_pair_distance,
    input  logic                          i_last_cell,
    output logic [((MAX_REF_FRAMES > 1) ? $clog2(MAX_REF_FRAMES) : 1)-1:0] o_col,
    output blsim_pkg::t_cell_ctl          o_ctl
);
    import blsim_pkg::*;

    localparam int AW  = (MAX_REF_FRAMES > 1) ? $clog2(MAX_REF_FRAMES) : 1;
    localparam int CLW = $clog2(MAX_REF_FRAMES + 1);
    localparam int WW  = (REFLEN_W > CLW) ? REFLEN_W : CLW;
    localparam int RW  = $clog2(MAX_INPUT_FRAMES + 2);
    localparam int G1  = (RW > AW + 1) ? RW : AW + 1;
    localparam int GW  = (G1 > BAND_W) ? G1 : BAND_W;

    logic [REFLEN_W-1:0] r_ref_length;
    logic [DIST_W-1:0]   r_threshold;
    logic [BAND_W-1:0]   r_band;
    logic [AW-1:0]       r_col;
    logic [RW-1:0]       r_row;
    logic                r_ovf;

    logic [WW-1:0] ref_w;
    logic [WW-1:0] len;
    logic [WW-1:0] col_w;
    logic [WW-1:0] col_eff;
    logic [WW-1:0] col_inc;
    logic [GW-1:0] i_g;
    logic [GW-1:0] j_g;
    logic [GW-1:0] gap;
    logic          row_over;
    logic [RW-1:0] n_row;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_length <= REFLEN_W'(1);
            r_threshold  <= '0;
            r_band       <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_REF_LENGTH:      r_ref_length <= i_cfg.data[REFLEN_W-1:0];
                REG_MATCH_THRESHOLD: r_threshold  <= i_cfg.data[DIST_W-1:0];
                REG_BAND_WIDTH:      r_band       <= i_cfg.data[BAND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        ref_w = WW'(r_ref_length);
        if (ref_w == '0) begin
            len = WW'(1);
        end else if (ref_w > WW'(MAX_REF_FRAMES)) begin
            len = WW'(MAX_REF_FRAMES);
        end else begin
            len = ref_w;
        end
        col_w   = WW'(r_col);
        col_eff = (col_w >= len) ? (len - WW'(1)) : col_w;
        col_inc = col_eff + WW'(1);
        i_g     = GW'(r_row);
        j_g     = GW'(col_eff) + GW'(1);
        gap     = (i_g > j_g) ? (i_g - j_g) : (j_g - i_g);
        row_over = r_row > RW'(MAX_INPUT_FRAMES);
        n_row   = row_over ? r_row : (r_row + RW'(1));
    end

    assign o_col          = col_eff[AW-1:0];
    assign o_ctl.match    = (gap <= GW'(r_band)) && (i_pair_distance < r_threshold);
    assign o_ctl.first_row = r_row <= RW'(1);
    assign o_ctl.col_zero = col_eff == '0;
    assign o_ctl.last     = i_last_cell;
    assign o_ctl.too_long = r_ovf || row_over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= RW'(1);
            r_ovf <= 1'b0;
        end else if (i_load) begin
            if (i_last_cell) begin
                r_col <= '0;
                r_row <= RW'(1);
                r_ovf <= 1'b0;
            end else if (col_inc >= len) begin
                r_col <= '0;
                r_row <= n_row;
                if (n_row > RW'(MAX_INPUT_FRAMES)) begin
                    r_ovf <= 1'b1;
                end
            end else begin
                r_col <= col_inc[AW-1:0];
            end
        end
    end

endmodule

// File: design/blsim_cell.sv
// ----------------------------------------------------------------------------
// blsim_cell
// Cell stage: takes the row-buffer read, forms the LCSS cell value, writes
// it back and holds the result register for the final cell.
// ----------------------------------------------------------------------------
`include "banded_lcss_similarity_assert.svh"

module blsim_cell #(
    parameter int AW = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  blsim_pkg::t_cell_ctl i_ctl,
    input  logic [AW-1:0]        i_col,
    input  blsim_pkg::t_val      i_rdata,
    output logic                 o_in_ready,
    output logic                 o_we,
    output logic [AW-1:0]        o_waddr,
    output blsim_pkg::t_val      o_wdata,
    blsim_out_if.source          o_out
);
    import blsim_pkg::*;

    logic      r_s1_valid;
    t_cell_ctl r_ctl;
    logic [AW-1:0] r_col;
    logic      r_byp_hit;
    t_val      r_byp_data;
    t_val      r_left;
    t_val      r_diag;
    logic      r_out_valid;
    t_val      r_out_len;
    logic      r_out_tl;

    logic s1_go;
    t_val up_v;
    t_val left_v;
    t_val diag_v;
    t_val val;

    always_comb begin
        s1_go  = r_s1_valid && (!r_ctl.last || !r_out_valid || o_out.ready);
        up_v   = r_ctl.first_row ? '0 : (r_byp_hit ? r_byp_data : i_rdata);
        left_v = r_ctl.col_zero ? '0 : r_left;
        diag_v = r_ctl.col_zero ? '0 : r_diag;
        if (r_ctl.match) begin
            val = (diag_v == VALUE_CAP) ? VALUE_CAP : (diag_v + t_val'(1));
        end else begin
            val = (up_v > left_v) ? up_v : left_v;
        end
    end

    assign o_in_ready = !r_s1_valid || s1_go;
    assign o_we       = s1_go;
    assign o_waddr    = r_col;
    assign o_wdata    = val;

    // same-address write in the read cycle: forward it
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ctl      <= i_ctl;
            r_col      <= i_col;
            r_byp_hit  <= s1_go && (r_col == i_col);
            r_byp_data <= val;
        end
        if (s1_go && r_ctl.last) begin
            r_out_len <= val;
            r_out_tl  <= r_ctl.too_long;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_diag      <= '0;
        end else begin
            if (i_load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_left <= val;
                r_diag <= up_v;
            end
            if (s1_go && r_ctl.last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.lcss_length = r_out_len;
    assign o_out.too_long    = r_out_tl;

    `BLSIM_ASSERT_IMP(a_stall_only_on_result, r_s1_valid && !s1_go,
        r_ctl.last && r_out_valid && !o_out.ready, "cell stage stalled without result backpressure")
    `BLSIM_ASSERT_IMP(a_load_needs_room, i_load, o_in_ready, "cell loaded while stage busy")
    `BLSIM_ASSERT_NXT(a_last_gives_result, s1_go && r_ctl.last, r_out_valid,
        "final cell did not produce a result")
    `BLSIM_ASSERT_IMP(a_max_rule, s1_go && !r_ctl.match, (val >= up_v) && (val >= left_v),
        "unmatched cell below its neighbors")

endmodule

// File: design/banded_lcss_similarity.sv
// ----------------------------------------------------------------------------
// banded_lcss_similarity
// Banded LCSS score over a stream of pairwise frame distances, one DP cell
// per transaction, previous row held in a RAM.
//
//   channel  | dir | payload                        | handshake
//   i_in     | in  | pair_distance[31:0], last_cell | valid/ready
//   o_out    | out | lcss_length[10:0], too_long    | valid/ready
//   i_cfg    | in  | index[1:0], data[31:0]         | valid/ready, ready tied high
//
// One cell per cycle while the cell stage is not stalled. A final cell's RAM
// read is registered at its transaction edge, then the cell stage forms its
// value and loads it into the result register, which drives o_out.valid.
// The row-buffer RAM read/write pair sets the cell rate.
// Synchronous active-low reset; RAM contents are not cleared.
// Input stalls only while a result waits in the output register and the
// next final cell reaches the cell stage.
// ----------------------------------------------------------------------------
module banded_lcss_similarity #(
    parameter int MAX_REF_FRAMES   = 1024,
    parameter int MAX_INPUT_FRAMES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    blsim_in_if.sink    i_in,
    blsim_out_if.source o_out,
    blsim_cfg_if.sink   i_cfg
);
    import blsim_pkg::*;

    localparam int AW = (MAX_REF_FRAMES > 1) ? $clog2(MAX_REF_FRAMES) : 1;

    logic          load;
    logic          in_ready;
    logic [AW-1:0] col;
    t_cell_ctl     ctl;
    t_val          rdata;
    logic          we;
    logic [AW-1:0] waddr;
    t_val          wdata;

    assign i_in.ready = in_ready;
    assign load       = i_in.valid && in_ready;

    blsim_seq #(
        .MAX_REF_FRAMES   (MAX_REF_FRAMES),
        .MAX_INPUT_FRAMES (MAX_INPUT_FRAMES)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (i_cfg),
        .i_load          (load),
        .i_pair_distance (i_in.pair_distance),
        .i_last_cell     (i_in.last_cell),
        .o_col           (col),
        .o_ctl           (ctl)
    );

    blsim_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_REF_FRAMES)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (load),
        .i_raddr (col),
        .o_rdata (rdata)
    );

    blsim_cell #(
        .AW (AW)
    ) u_cell (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_ctl      (ctl),
        .i_col      (col),
        .i_rdata    (rdata),
        .o_in_ready (in_ready),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_out      (o_out)
    );

endmodule
